@@ hdl/md5_pkg.sv @@
// md5_pkg: shared types, initial vector and round constants for the MD5 digest block.
// Used by md5_core and md5_message_digest; depends on nothing.
package md5_pkg;

    typedef logic [31:0] word_t;
    typedef logic [3:0][31:0] chain_t;

    // Control from the byte sequencer to the compression core
    typedef struct packed {
        logic        start;      // block complete, begin 64 rounds
        logic        reseed;     // return chaining words to the initial vector
        logic        word_we;    // write one assembled 32-bit word
        logic [3:0]  word_addr;
        logic [31:0] word_data;
    } core_ctrl_t;

    localparam chain_t INIT_CHAIN = {32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301};

    function automatic logic [31:0] sine_key(input logic [5:0] idx);
        logic [31:0] k;
        begin
            case (idx)
                6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
                6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
                6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
                6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
                6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
                6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
                6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
                6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
                6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
                6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
                6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
                6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
                6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
                6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
                6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
                6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
                6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
                6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
                6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
                6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
                6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
                6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
                6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
                6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
                6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
                6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
                6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
                6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
                6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
                6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
                6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
                6'd62: k = 32'h2AD7D2BB;  default: k = 32'hEB86D391;
            endcase
            return k;
        end
    endfunction

    // Left-rotate amount: four per quarter, selected by round[5:4] and round[1:0]
    function automatic logic [4:0] rot_amount(input logic [5:0] idx);
        logic [4:0] r;
        begin
            case ({idx[5:4], idx[1:0]})
                4'h0: r = 5'd7;   4'h1: r = 5'd12;  4'h2: r = 5'd17;  4'h3: r = 5'd22;
                4'h4: r = 5'd5;   4'h5: r = 5'd9;   4'h6: r = 5'd14;  4'h7: r = 5'd20;
                4'h8: r = 5'd4;   4'h9: r = 5'd11;  4'hA: r = 5'd16;  4'hB: r = 5'd23;
                4'hC: r = 5'd6;   4'hD: r = 5'd10;  4'hE: r = 5'd15;  default: r = 5'd21;
            endcase
            return r;
        end
    endfunction

    // Message word index used by each round
    function automatic logic [3:0] word_index(input logic [5:0] idx);
        logic [3:0] g;
        begin
            case (idx[5:4])
                2'd0:    g = idx[3:0];
                2'd1:    g = 4'((idx[3:0] * 4'd5) + 4'd1);
                2'd2:    g = 4'((idx[3:0] * 4'd3) + 4'd5);
                default: g = 4'(idx[3:0] * 4'd7);
            endcase
            return g;
        end
    endfunction

endpackage

@@ hdl/md5_core.sv @@
// md5_core: 16-word block memory and the MD5 round unit, one round per cycle.
// Holds the four chaining words. Depends on md5_pkg.
module md5_core (
    input  logic                clk,
    input  logic                rst_n,
    input  md5_pkg::core_ctrl_t ctrl,
    output logic                done,
    output md5_pkg::chain_t     chain
);

    localparam logic [5:0] LAST_ROUND = 6'd63;

    logic [31:0]     word_mem [16];
    md5_pkg::chain_t chain_reg;

    // fetch stage
    logic            fetch_on_reg;
    logic [5:0]      fetch_cnt_reg;
    // read stage
    logic            rd_v_reg;
    logic [31:0]     rd_data_reg;
    logic [5:0]      rd_idx_reg;
    // key add stage
    logic            kw_v_reg;
    logic [31:0]     kw_reg;
    logic [5:0]      kw_idx_reg;
    // round registers
    logic [31:0]     a_reg, b_reg, c_reg, d_reg;
    logic            fin_reg;

    logic [31:0]     f_val;
    logic [31:0]     t_sum;
    logic [63:0]     t_dbl;
    logic [31:0]     b_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.word_we)
        begin
            word_mem[ctrl.word_addr] <= ctrl.word_data;
        end
        if (fetch_on_reg)
        begin
            rd_data_reg <= word_mem[md5_pkg::word_index(fetch_cnt_reg)];
        end
    end

    always_comb
    begin
        case (kw_idx_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        t_sum  = f_val + a_reg + kw_reg;
        t_dbl  = {t_sum, t_sum} << md5_pkg::rot_amount(kw_idx_reg);
        b_next = b_reg + t_dbl[63:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_on_reg  <= 1'b0;
            fetch_cnt_reg <= '0;
            rd_v_reg      <= 1'b0;
            kw_v_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            chain_reg     <= md5_pkg::INIT_CHAIN;
        end
        else
        begin
            rd_v_reg <= fetch_on_reg;
            kw_v_reg <= rd_v_reg;
            fin_reg  <= kw_v_reg && (kw_idx_reg == LAST_ROUND);
            if (ctrl.start)
            begin
                fetch_on_reg  <= 1'b1;
                fetch_cnt_reg <= '0;
            end
            else if (fetch_on_reg)
            begin
                fetch_cnt_reg <= fetch_cnt_reg + 6'd1;
                if (fetch_cnt_reg == LAST_ROUND)
                begin
                    fetch_on_reg <= 1'b0;
                end
            end
            if (ctrl.reseed)
            begin
                chain_reg <= md5_pkg::INIT_CHAIN;
            end
            else if (fin_reg)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= fetch_cnt_reg;
        kw_reg     <= rd_data_reg + md5_pkg::sine_key(rd_idx_reg);
        kw_idx_reg <= rd_idx_reg;
        if (ctrl.start)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (kw_v_reg)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_next;
        end
    end

    assign done  = fin_reg;
    assign chain = chain_reg;

endmodule

@@ hdl/md5_message_digest.sv @@
// md5_message_digest: top level of the MD5 digest block; byte sequencer, padding, output.
// Depends on md5_pkg and md5_core.
//
// Usage:
//   Input channel (in_valid / in_stall, payload action, data_byte): a word with
//   action 0 absorbs data_byte; action 1 finishes the message. Output channel
//   (out_valid / out_stall, payload digest_byte, last_digest_byte) carries the
//   16 digest bytes after a finish, chaining word 0 low byte first, with
//   last_digest_byte set on the sixteenth.
// Timing:
//   Every 64th byte starts a compression that holds in_stall high while it
//   runs: memory read and key add stages ahead of 64 rounds of the shared
//   round unit, then the chaining-word add. A finish feeds 0x80, zeros and
//   the 8 length bytes through the same byte path at one per cycle outside
//   compressions, runs one or two compressions, then presents the digest at
//   one byte per cycle while out_stall is low.
// Reset clears the sequencer, fill count and length and loads the initial
// vector. The block store is not cleared. While out_stall is high the current
// digest byte is held; after the last byte is taken the block reseeds itself
// and drops in_stall.
module md5_message_digest (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] digest_byte,
    output logic       last_digest_byte
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PAD  = 2'd1;
    localparam logic [1:0] S_COMP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    // padding phases
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_MARK = 2'd1;
    localparam logic [1:0] PH_ZERO = 2'd2;
    localparam logic [1:0] PH_LEN  = 2'd3;

    localparam logic       ACT_ABSORB = 1'b0;
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_SLOT  = 6'd63;
    localparam logic [3:0] LAST_OUT   = 4'd15;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  fill_reg, fill_next;
    logic [23:0] acc_reg, acc_next;      // first three bytes of the current word
    logic [60:0] byte_cnt_reg, byte_cnt_next;
    logic [3:0]  out_cnt_reg, out_cnt_next;

    logic        abs_en;
    logic [7:0]  abs_byte;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;

    md5_pkg::core_ctrl_t ctrl;
    md5_pkg::chain_t     chain;
    logic                core_done;

    md5_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .done  (core_done),
        .chain (chain)
    );

    // message length in bits, little-endian byte picked by the block offset
    assign bit_len  = {byte_cnt_reg, 3'b000};
    assign len_byte = bit_len[{fill_reg[2:0], 3'b000} +: 8];

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        fill_next     = fill_reg;
        acc_next      = acc_reg;
        byte_cnt_next = byte_cnt_reg;
        out_cnt_next  = out_cnt_reg;
        ctrl          = '0;
        abs_en        = 1'b0;
        abs_byte      = data_byte;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_ABSORB)
                    begin
                        abs_en        = 1'b1;
                        byte_cnt_next = byte_cnt_reg + 61'd1;
                    end
                    else
                    begin
                        state_next = S_PAD;
                        phase_next = PH_MARK;
                    end
                end
            end
            S_PAD:
            begin
                abs_en = 1'b1;
                case (phase_reg)
                    PH_MARK:
                    begin
                        abs_byte   = PAD_MARK;
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO:
                    begin
                        if (fill_reg != LEN_OFFSET)
                        begin
                            abs_byte = 8'h00;
                        end
                        else
                        begin
                            abs_byte   = len_byte;
                            phase_next = PH_LEN;
                        end
                    end
                    default:
                    begin
                        abs_byte = len_byte;
                    end
                endcase
            end
            S_COMP:
            begin
                if (core_done)
                begin
                    if (phase_reg == PH_LEN)
                    begin
                        state_next   = S_EMIT;
                        out_cnt_next = '0;
                    end
                    else if (phase_reg == PH_NONE)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_stall)
                begin
                    out_cnt_next = out_cnt_reg + 4'd1;
                    if (out_cnt_reg == LAST_OUT)
                    begin
                        state_next    = S_IDLE;
                        phase_next    = PH_NONE;
                        byte_cnt_next = '0;
                        ctrl.reseed   = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // shared byte path: pack little-endian, write each full word
        if (abs_en)
        begin
            fill_next = fill_reg + 6'd1;
            case (fill_reg[1:0])
                2'd0: acc_next[7:0]   = abs_byte;
                2'd1: acc_next[15:8]  = abs_byte;
                2'd2: acc_next[23:16] = abs_byte;
                default:
                begin
                    ctrl.word_we   = 1'b1;
                    ctrl.word_addr = fill_reg[5:2];
                    ctrl.word_data = {abs_byte, acc_reg};
                end
            endcase
            if (fill_reg == LAST_SLOT)
            begin
                ctrl.start = 1'b1;
                state_next = S_COMP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_NONE;
            fill_reg     <= '0;
            byte_cnt_reg <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            fill_reg     <= fill_next;
            byte_cnt_reg <= byte_cnt_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = (state_reg == S_EMIT);
    assign digest_byte      = chain[out_cnt_reg[3:2]][{out_cnt_reg[1:0], 3'b000} +: 8];
    assign last_digest_byte = (out_cnt_reg == LAST_OUT);

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for md5_message_digest, the byte-serial MD5 digest block.
// Holds its own MD5 predictor and compares the 16 digest bytes that each finish returns.
// Depends only on the RTL (md5_pkg, md5_core, md5_message_digest).
`timescale 1ns / 100ps

module tb_top;

    // Longest quiet stretch allowed. A finish with padding into a second block needs
    // the pad bytes and two compressions before the first digest byte, plus a stall
    // burst on either side, so QUIET_LIMIT leaves a wide margin.
    localparam int QUIET_LIMIT = 2000;

    // Input word codes
    typedef enum logic {
        ACT_ABSORB = 1'b0,
        ACT_FINISH = 1'b1
    } action_t;

    // Chaining-word initial vector
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    // Per-round additive constants, index 0 leftmost
    localparam logic [0:63][31:0] ROUND_KEY = {
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };

    // Left-rotate amounts: four per quarter, picked by round / 16 and round % 4
    localparam logic [0:15][4:0] ROT_AMT = {
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    // One expected digest byte
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } digest_exp_t;

    // DUT connections; every input is known from time zero
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       action = ACT_ABSORB;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] digest_byte;
    logic       last_digest_byte;

    // Predictor state: chaining words, block buffer, fill pointer, bit length
    logic [31:0] chain_st [4];
    logic [7:0]  blk_st [64];
    logic [5:0]  fill_st;
    logic [63:0] bitlen_st;

    digest_exp_t pending_digest [$];
    digest_exp_t head_exp;

    bit idle_on = 1'b1;   // random idling on both sides; cleared for the last part
    int error_count = 0;
    int words_sent = 0;
    int messages_sent = 0;
    int digest_bytes_seen = 0;
    int quiet_cycles = 0;
    int stall_run = 0;

    md5_message_digest dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .digest_byte      (digest_byte),
        .last_digest_byte (last_digest_byte)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // MD5 predictor
    // ------------------------------------------------------------------

    // Back to the post-reset state: IV loaded, empty buffer, zero length.
    // The buffer content is left alone, just as in the block.
    function automatic void reseed_model();
        chain_st[0] = IV_A;
        chain_st[1] = IV_B;
        chain_st[2] = IV_C;
        chain_st[3] = IV_D;
        fill_st     = '0;
        bitlen_st   = '0;
    endfunction

    // 64 rounds over the full buffer, folded into the chaining words
    function automatic void compress_block();
        logic [31:0] m [16];
        logic [31:0] a, b, c, d, f, t;
        int          g, sh;
        for (int k = 0; k < 16; k++)
            m[k] = {blk_st[4*k+3], blk_st[4*k+2], blk_st[4*k+1], blk_st[4*k]};
        a = chain_st[0];
        b = chain_st[1];
        c = chain_st[2];
        d = chain_st[3];
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:       begin f = (b & c) | (~b & d); g = i;                end
                1:       begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
                2:       begin f = b ^ c ^ d;          g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d);       g = (7 * i) % 16;     end
            endcase
            t  = f + a + ROUND_KEY[i] + m[g];
            sh = ROT_AMT[(i / 16) * 4 + (i % 4)];
            a  = d;
            d  = c;
            c  = b;
            b  = b + ((t << sh) | (t >> (32 - sh)));
        end
        chain_st[0] += a;
        chain_st[1] += b;
        chain_st[2] += c;
        chain_st[3] += d;
    endfunction

    // Buffer one byte; the 6-bit fill pointer wraps to zero on a full block
    function automatic void absorb_byte(input logic [7:0] value);
        blk_st[fill_st] = value;
        fill_st   = fill_st + 6'd1;
        bitlen_st = bitlen_st + 64'd8;
        if (fill_st == 6'd0)
            compress_block();
    endfunction

    // Work out the effect of one accepted word; a finish queues 16 digest bytes
    function automatic void predict_word(input logic act, input logic [7:0] value);
        logic [63:0] msg_bits;
        digest_exp_t e;
        if (act == ACT_ABSORB)
        begin
            absorb_byte(value);
            return;
        end
        // Length is latched before padding adds to it
        msg_bits = bitlen_st;
        absorb_byte(PAD_MARK);
        while (fill_st != LEN_OFFSET)
            absorb_byte(8'h00);
        for (int i = 0; i < 8; i++)
            absorb_byte(msg_bits[8*i +: 8]);
        for (int i = 0; i < 16; i++)
        begin
            e.value = chain_st[i / 4][8 * (i % 4) +: 8];
            e.last  = (i == 15);
            pending_digest.push_back(e);
        end
        reseed_model();
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drive one word and hold it until taken. Valid is only dropped for an idle
    // burst, so back-to-back words keep it high without a glitch.
    task automatic send_word(input logic act, input logic [7:0] value);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= value;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_word(act, value);
        words_sent++;
    endtask

    // Random-content message of the given length, then a finish whose
    // data byte is random too (the block must ignore it)
    task automatic send_message(input int len);
        for (int k = 0; k < len; k++)
            send_word(ACT_ABSORB, 8'($urandom_range(0, 255)));
        send_word(ACT_FINISH, 8'($urandom_range(0, 255)));
        messages_sent++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Finish straight after reset: digest of the empty message
    task automatic test_empty_message();
        send_word(ACT_FINISH, 8'h00);
        messages_sent++;
    endtask

    // A second finish at once must start again from the initial vector
    task automatic test_reseed_after_finish();
        send_word(ACT_FINISH, 8'hFF);
        messages_sent++;
    endtask

    // Data bytes at and around the extremes, finish with all-ones data
    task automatic test_byte_extremes();
        send_word(ACT_ABSORB, 8'h00);
        send_word(ACT_ABSORB, 8'hFF);
        send_word(ACT_ABSORB, 8'h80);
        send_word(ACT_ABSORB, 8'h7F);
        send_word(ACT_ABSORB, 8'h01);
        send_word(ACT_ABSORB, 8'hFE);
        send_word(ACT_ABSORB, 8'h55);
        send_word(ACT_ABSORB, 8'hAA);
        send_word(ACT_FINISH, 8'hFF);
        messages_sent++;
    endtask

    // "abc": a short, well-known message
    task automatic test_short_text();
        send_word(ACT_ABSORB, 8'h61);
        send_word(ACT_ABSORB, 8'h62);
        send_word(ACT_ABSORB, 8'h63);
        send_word(ACT_FINISH, 8'h00);
        messages_sent++;
    endtask

    // 56..63 bytes: the length field no longer fits, so padding spills into a
    // second block and two compressions run
    task automatic test_padding_crossing();
        send_message($urandom_range(56, 63));
    endtask

    // Mostly short messages; now and then one that just fits (55) or fills a
    // whole block (64) before the finish
    task automatic test_random_messages(input int budget);
        int start;
        int len;
        start = words_sent;
        while (words_sent - start < budget)
        begin
            if ($urandom_range(0, 9) == 0)
                len = ($urandom_range(0, 1) != 0) ? 55 : 64;
            else
                len = $urandom_range(0, 12);
            send_message(len);
        end
    endtask

    // Last stretch: no idling on either side, words and digest bytes at full rate
    task automatic test_back_to_back(input int budget);
        int start;
        idle_on = 1'b0;
        start = words_sent;
        while (words_sent - start < budget)
            send_message($urandom_range(0, 8));
    endtask

    // ------------------------------------------------------------------
    // Output side: stall generator, checker, watchdog
    // ------------------------------------------------------------------

    // Random stall bursts on out_stall while idling is on
    always @(posedge clk)
    begin
        if (stall_run != 0)
        begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end
        else if (rst_n && idle_on && $urandom_range(0, 4) == 0)
        begin
            out_stall <= 1'b1;
            stall_run <= $urandom_range(0, 5);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Each digest byte taken is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            digest_bytes_seen++;
            if (pending_digest.size() == 0)
            begin
                error_count++;
                $display("%0t: digest byte with none expected: got %02h last %b",
                         $time, digest_byte, last_digest_byte);
            end
            else
            begin
                head_exp = pending_digest.pop_front();
                if (digest_byte !== head_exp.value)
                begin
                    error_count++;
                    $display("%0t: digest_byte expected %02h actual %02h",
                             $time, head_exp.value, digest_byte);
                end
                if (last_digest_byte !== head_exp.last)
                begin
                    error_count++;
                    $display("%0t: last_digest_byte expected %b actual %b",
                             $time, head_exp.last, last_digest_byte);
                end
            end
        end
    end

    // Ends the run when quiet_cycles, counting clocks in which neither channel moves, reaches QUIET_LIMIT
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d digest bytes outstanding",
                         $time, QUIET_LIMIT, pending_digest.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        reseed_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        test_empty_message();
        test_reseed_after_finish();
        test_byte_extremes();
        test_short_text();

        // Random part
        test_padding_crossing();
        test_random_messages(60);
        test_back_to_back(25);

        in_valid <= 1'b0;

        // Drain, then give the block time to reseed and show any stray output
        while (pending_digest.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d words in %0d messages; %0d digest bytes compared.",
                 words_sent, messages_sent, digest_bytes_seen);
        $display("Covered empty message, byte extremes, padding past a block, full blocks.");
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
